/* src/cdq_pkg.sv */
// shared types and constants for the circular deque
`timescale 1ns / 1ps

package cdq_pkg;

	localparam int CNT_W  = 5;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_PEEK_FRONT = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]               op;
		logic signed [DATA_W-1:0] data;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_data;
		logic [1:0]               status;
		logic                     now_empty;
		logic                     now_full;
		logic [CNT_W-1:0]         occupancy;
	} out_item_t;

	typedef struct packed {
		logic              shift_right;
		logic              shift_left;
		logic              load_rear;
		logic [CNT_W-1:0]  count;
		logic [DATA_W-1:0] data;
	} cell_ctrl_t;

endpackage

/* src/circular_deque.sv */
// circular deque top level: request handling, occupancy count and cell row
`timescale 1ns / 1ps

// Double-ended queue of 32-bit entries held in a row of DEPTH cells, at most 31. The
// capacity register sets how many cells are usable: 0 acts as 1, a value above the row
// length acts as the row length, and reset leaves it at the row length. The front
// always sits in the first cell: a front push shifts the row one cell right, a front pop
// one cell left, a rear push loads the cell at the current occupancy, and a rear pop
// reads the last occupied cell through an OR across the row. One request is taken every
// clock cycle while the input does not stall; its result is written to the output
// register, and the input stalls only while that register is held by a stalled output.
// A write to the capacity register empties the deque and is taken in any cycle.
module circular_deque #(
	parameter int DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  cdq_pkg::in_item_t           in_item,
	output logic                        out_valid,
	input  logic                        out_stall,
	output cdq_pkg::out_item_t          out_item,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [cdq_pkg::CNT_W-1:0]   cfg_data
);

	localparam int CNT_MAX = (1 << cdq_pkg::CNT_W) - 1;
	localparam int CAP_MAX = (DEPTH > CNT_MAX) ? CNT_MAX : DEPTH;

	logic [cdq_pkg::CNT_W-1:0]  capacity_q;
	logic [cdq_pkg::CNT_W-1:0]  count_q;
	logic                       out_valid_q;
	cdq_pkg::out_item_t         out_q;

	logic [cdq_pkg::CNT_W-1:0]  cap_eff;
	logic [cdq_pkg::CNT_W-1:0]  count_nxt;
	logic                       full;
	logic                       empty;
	logic                       accept;
	logic                       cfg_wr;
	logic                       do_right;
	logic                       do_left;
	logic                       do_rear;
	logic [cdq_pkg::DATA_W-1:0] res;
	cdq_pkg::status_t           st;
	cdq_pkg::cell_ctrl_t        ctrl;
	cdq_pkg::out_item_t         out_nxt;

	logic [cdq_pkg::DATA_W-1:0] cell_val [CAP_MAX];
	logic [cdq_pkg::DATA_W-1:0] cell_rear [CAP_MAX];
	logic [cdq_pkg::DATA_W-1:0] front;
	logic [cdq_pkg::DATA_W-1:0] rear_val;

	assign in_stall  = out_valid_q & out_stall;
	assign accept    = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = cdq_pkg::CNT_W'(1);
		end else if (int'(capacity_q) > CAP_MAX) begin
			cap_eff = cdq_pkg::CNT_W'(CAP_MAX);
		end else begin
			cap_eff = capacity_q;
		end
	end

	assign full  = count_q >= cap_eff;
	assign empty = count_q == '0;
	assign front = cell_val[0];

	always_comb begin
		rear_val = '0;
		for (int i = 0; i < CAP_MAX; i++) begin
			rear_val = rear_val | cell_rear[i];
		end
	end

	always_comb begin
		do_right  = 1'b0;
		do_left   = 1'b0;
		do_rear   = 1'b0;
		res       = '0;
		st        = cdq_pkg::ST_OK;
		count_nxt = count_q;
		case (cdq_pkg::op_t'(in_item.op))
			cdq_pkg::OP_PUSH_FRONT: begin
				if (full) begin
					st = cdq_pkg::ST_FULL;
				end else begin
					do_right  = 1'b1;
					count_nxt = count_q + 1'b1;
				end
			end
			cdq_pkg::OP_PUSH_REAR: begin
				if (full) begin
					st = cdq_pkg::ST_FULL;
				end else begin
					do_rear   = 1'b1;
					count_nxt = count_q + 1'b1;
				end
			end
			cdq_pkg::OP_POP_FRONT: begin
				if (empty) begin
					st = cdq_pkg::ST_EMPTY;
				end else begin
					res       = front;
					do_left   = 1'b1;
					count_nxt = count_q - 1'b1;
				end
			end
			cdq_pkg::OP_POP_REAR: begin
				if (empty) begin
					st = cdq_pkg::ST_EMPTY;
				end else begin
					res       = rear_val;
					count_nxt = count_q - 1'b1;
				end
			end
			cdq_pkg::OP_PEEK_FRONT: begin
				if (empty) begin
					st = cdq_pkg::ST_EMPTY;
				end else begin
					res = front;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ctrl.shift_right = accept & ~cfg_wr & do_right;
		ctrl.shift_left  = accept & ~cfg_wr & do_left;
		ctrl.load_rear   = accept & ~cfg_wr & do_rear;
		ctrl.count       = count_q;
		ctrl.data        = in_item.data;
		out_nxt.result_data = res;
		out_nxt.status      = st;
		out_nxt.now_empty   = count_nxt == '0;
		out_nxt.now_full    = count_nxt >= cap_eff;
		out_nxt.occupancy   = count_nxt;
	end

	for (genvar g = 0; g < CAP_MAX; g++) begin : g_cell
		logic [cdq_pkg::DATA_W-1:0] left_in;
		logic [cdq_pkg::DATA_W-1:0] right_in;
		if (g == 0) begin : g_first
			assign left_in = in_item.data;
		end else begin : g_mid
			assign left_in = cell_val[g-1];
		end
		if (g == CAP_MAX - 1) begin : g_last
			assign right_in = cell_val[g];
		end else begin : g_inner
			assign right_in = cell_val[g+1];
		end
		cdq_cell #(
			.IDX(g)
		) u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.left  (left_in),
			.right (right_in),
			.value (cell_val[g]),
			.rear  (cell_rear[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= cdq_pkg::CNT_W'(CAP_MAX);
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				capacity_q <= cfg_data;
				count_q    <= '0;
			end else if (accept) begin
				count_q <= count_nxt;
			end
			out_valid_q <= accept | in_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= out_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_eff || $past(cfg_wr))
		else $error("occupancy above capacity");

	a_cfg_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> count_q == '0)
		else $error("capacity write did not empty the deque");

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q)
		else $error("input stalled with no result waiting");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg_wr) |=> (count_q == $past(count_q) ||
			count_q == $past(count_q) + 1'b1 || count_q == $past(count_q) - 1'b1))
		else $error("occupancy moved by more than one");

endmodule

/* src/cdq_cell.sv */
// one storage cell of the deque row
`timescale 1ns / 1ps

module cdq_cell #(
	parameter int IDX = 0
) (
	input  logic                       clk,
	input  cdq_pkg::cell_ctrl_t        ctrl,
	input  logic [cdq_pkg::DATA_W-1:0] left,
	input  logic [cdq_pkg::DATA_W-1:0] right,
	output logic [cdq_pkg::DATA_W-1:0] value,
	output logic [cdq_pkg::DATA_W-1:0] rear
);

	// cells past the largest count are never the rear slot
	localparam int  CNT_MAX   = (1 << cdq_pkg::CNT_W) - 1;
	localparam bit  CAN_LOAD  = (IDX <= CNT_MAX);
	localparam bit  CAN_REAR  = (IDX + 1 <= CNT_MAX);
	localparam logic [cdq_pkg::CNT_W-1:0] LOAD_AT = CAN_LOAD ? cdq_pkg::CNT_W'(IDX) : '0;
	localparam logic [cdq_pkg::CNT_W-1:0] REAR_AT = CAN_REAR ? cdq_pkg::CNT_W'(IDX + 1) : '0;

	logic [cdq_pkg::DATA_W-1:0] data_q;
	logic                       is_rear;
	logic                       is_tail;

	assign is_rear = CAN_REAR && (ctrl.count == REAR_AT);
	assign is_tail = CAN_LOAD && (ctrl.count == LOAD_AT);

	always_ff @(posedge clk) begin
		if (ctrl.shift_right) begin
			data_q <= left;
		end else if (ctrl.shift_left) begin
			data_q <= right;
		end else if (ctrl.load_rear && is_tail) begin
			data_q <= ctrl.data;
		end
	end

	assign value = data_q;
	assign rear  = is_rear ? data_q : '0;

endmodule
